[sv/ssrf_pkg.sv]
// ssrf_pkg: shared constants for the SPI slave register file.
// No dependencies; imported by the channel interfaces and the top level.
package ssrf_pkg;

   localparam int BYTE_W = 8;

   // Command codes on the request channel
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // Header byte layout
   localparam int                HDR_WRITE_BIT = 7;
   localparam logic [BYTE_W-1:0] HDR_ADDR_MASK = 8'h7F;
   localparam logic [BYTE_W-1:0] REPLY_ZERO    = 8'h00;

endpackage

[sv/ssrf_req_if.sv]
// ssrf_req_if: request channel (received byte or timeout event).
// Depends on ssrf_pkg for the byte width.
interface ssrf_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [ssrf_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

[sv/ssrf_rsp_if.sv]
// ssrf_rsp_if: result channel (reply byte and watchdog kick).
// Depends on ssrf_pkg for the byte width.
interface ssrf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ssrf_pkg::BYTE_W-1:0] tx_byte;
   logic                        watchdog_kick;

   modport source (output valid, output tx_byte, output watchdog_kick, input ready);
   modport sink   (input valid, input tx_byte, input watchdog_kick, output ready);
endinterface

[sv/ssrf_ram.sv]
// ssrf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssrf_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/spi_slave_register_file_unit.sv]
// spi_slave_register_file_unit: SPI slave byte register map with auto-increment.
// Depends on ssrf_pkg, ssrf_req_if, ssrf_rsp_if and ssrf_ram.
//
//   channel   dir   payload                        transfer when
//   req_if    in    cmd, rx_byte                   valid && ready
//   rsp_if    out   tx_byte, watchdog_kick         valid && ready
//
// Cycles: one request transfer per clock unless stalled (see below); each
// request yields its reply in the result register in the cycle after the
// transfer, via register RAM's registered read port, read in the accept cycle.
// Reset: synchronous, active high; clears phase, pointer, timeout flag, the
// per-entry written bits and the result valid. Unwritten entries read 7 - i.
// Stalls: req_if.ready drops only while a result is held and not taken.
module spi_slave_register_file_unit #(
   parameter int REG_COUNT = 8
) (
   input logic        clock,
   input logic        reset,
   ssrf_req_if.sink   req_if,
   ssrf_rsp_if.source rsp_if
);

   import ssrf_pkg::*;

   // Pointer must hold REG_COUNT itself (one past the last register).
   localparam int PtrW = $clog2(REG_COUNT + 1);
   localparam int IdxW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_WRITE,
      PH_READ,
      PH_OUT
   } phase_type;

   // Transaction state
   phase_type            phase_ff, phase_in;
   logic [PtrW-1:0]      pointer_ff, pointer_in;
   logic                 timed_out_ff, timed_out_in;
   logic [REG_COUNT-1:0] written_ff;     // entry holds a written value

   // Result stage
   logic              rsp_valid_ff;
   logic              kick_ff, kick_in;
   logic              from_ram_ff;       // reply comes from the register file
   logic              use_init_ff;       // entry never written: use reset value
   logic [BYTE_W-1:0] init_ff;

   // Per-transfer decode
   logic              accept;
   logic              rd_en, wr_en;
   logic [IdxW-1:0]   rd_idx, wr_idx;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [BYTE_W-1:0] hdr_addr;
   phase_type         cur_phase;
   logic [PtrW-1:0]   ptr_next;

   // Output register empties or drains this cycle: take the next request.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign hdr_addr = req_if.rx_byte & HDR_ADDR_MASK;

   always_comb begin
      phase_in     = phase_ff;
      pointer_in   = pointer_ff;
      timed_out_in = timed_out_ff;
      kick_in      = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      rd_idx       = pointer_ff[IdxW-1:0];
      wr_idx       = pointer_ff[IdxW-1:0];
      ptr_next     = pointer_ff;
      cur_phase    = phase_ff;

      if (req_if.cmd == CMD_TIMEOUT) begin
         timed_out_in = 1'b1;
      end else begin
         // A byte after a timeout is always a header and does not kick.
         timed_out_in = 1'b0;
         kick_in      = !timed_out_ff;
         cur_phase    = timed_out_ff ? PH_HEADER : phase_ff;

         unique case (cur_phase)
            PH_HEADER: begin
               if (hdr_addr < BYTE_W'(REG_COUNT)) begin
                  pointer_in = PtrW'(hdr_addr);
                  if (req_if.rx_byte[HDR_WRITE_BIT]) begin
                     phase_in = PH_WRITE;
                  end else begin
                     rd_en      = 1'b1;
                     rd_idx     = hdr_addr[IdxW-1:0];
                     pointer_in = PtrW'(hdr_addr) + PtrW'(1);
                     phase_in   = PH_READ;
                  end
               end else begin
                  phase_in = PH_OUT;
               end
            end
            PH_WRITE: begin
               if (pointer_ff < PtrW'(REG_COUNT)) begin
                  wr_en    = 1'b1;
                  ptr_next = pointer_ff + PtrW'(1);
               end
               pointer_in = ptr_next;
               phase_in   = (ptr_next >= PtrW'(REG_COUNT)) ? PH_OUT : PH_WRITE;
            end
            PH_READ: begin
               if (pointer_ff >= PtrW'(REG_COUNT)) begin
                  phase_in = PH_OUT;
               end else begin
                  rd_en      = 1'b1;
                  pointer_in = pointer_ff + PtrW'(1);
                  phase_in   = PH_READ;
               end
            end
            PH_OUT: begin
               phase_in = PH_OUT;
            end
            default: begin
               phase_in = PH_OUT;
            end
         endcase
      end
   end

   ssrf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (REG_COUNT)
   ) u_regs (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_idx),
      .wr_data (req_if.rx_byte),
      .rd_en   (accept && rd_en),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pointer_ff   <= '0;
         timed_out_ff <= 1'b0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            pointer_ff   <= pointer_in;
            timed_out_ff <= timed_out_in;
            if (wr_en) begin
               written_ff[wr_idx] <= 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Result payload, no reset needed
      if (accept) begin
         kick_ff     <= kick_in;
         from_ram_ff <= rd_en;
         use_init_ff <= !written_ff[rd_idx];
         init_ff     <= BYTE_W'(7) - BYTE_W'(rd_idx);
      end
   end

   // RAM read data holds while stalled, since a read only fires on a transfer.
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.watchdog_kick = kick_ff;
   assign rsp_if.tx_byte       = !from_ram_ff ? REPLY_ZERO :
                                 (use_init_ff ? init_ff : ram_rd_data);

endmodule
